>>> rtl/ucc_pkg.sv
// ----------------------------------------------------------------------------
// ucc_pkg
// shared types, widths, codes and reset values of the occupancy counter
// ----------------------------------------------------------------------------
package ucc_pkg;

    // default parameter values
    localparam int LOG_DEPTH_DEF   = 5;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int ECHO_WIDTH_DEF  = 16;

    // fixed field widths
    localparam int THRESH_W    = 16;
    localparam int INTERVAL_W  = 18;
    localparam int LOCKOUT_W   = 21;
    localparam int TPS_W       = 20;
    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 2;
    localparam int TIME_W      = 17;
    localparam int COUNT_OUT_W = 16;
    localparam int LOG_INDEX_W = 3;
    localparam int PHASE_CNT_W = 4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_THRESHOLD   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_INTERVAL    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_TICKS    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 2'd3;

    // configuration reset values
    localparam logic [THRESH_W-1:0]   NEAR_THRESHOLD_RST   = 16'd1000;
    localparam logic [INTERVAL_W-1:0] READ_INTERVAL_RST    = 18'd200000;
    localparam logic [LOCKOUT_W-1:0]  LOCKOUT_TICKS_RST    = 21'd2000000;
    localparam logic [TPS_W-1:0]      TICKS_PER_SECOND_RST = 20'd1000000;

    // transaction codes
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_READ = 1'b1;
    localparam logic LOG_ENTRY = 1'b0;
    localparam logic LOG_EXIT  = 1'b1;

    // trigger timing in ticks
    localparam logic [PHASE_CNT_W-1:0] LOW_TICKS  = 4'd2;
    localparam logic [PHASE_CNT_W-1:0] HIGH_TICKS = 4'd10;

    // time of day limits
    localparam logic [6:0] SEC_MAX  = 7'd59;
    localparam logic [6:0] MIN_MAX  = 7'd59;
    localparam logic [5:0] HOUR_MAX = 6'd23;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_A_LOW   = 4'd1,
        PH_A_HIGH  = 4'd2,
        PH_A_WAIT  = 4'd3,
        PH_A_COUNT = 4'd4,
        PH_B_LOW   = 4'd5,
        PH_B_HIGH  = 4'd6,
        PH_B_WAIT  = 4'd7,
        PH_B_COUNT = 4'd8
    } phase_t;

    typedef struct packed {
        logic                   trig_a;
        logic                   trig_b;
        logic [COUNT_OUT_W-1:0] occupancy;
        logic [COUNT_OUT_W-1:0] peak;
        logic [COUNT_OUT_W-1:0] total;
        logic [TIME_W-1:0]      clock_time;
        logic                   entered;
        logic                   exited;
        logic [TIME_W-1:0]      log_time;
    } rsp_t;

    // advance packed hh:mm:ss by one second, wrapping after 23:59:59
    function automatic logic [TIME_W-1:0] clock_advance(input logic [TIME_W-1:0] t);
        logic [5:0] h;
        logic [6:0] m;
        logic [6:0] s;
        h = {1'b0, t[16:12]};
        m = {1'b0, t[11:6]};
        s = {1'b0, t[5:0]};
        s = s + 7'd1;
        if (s > SEC_MAX)
        begin
            s = 7'd0;
            m = m + 7'd1;
        end
        if (m > MIN_MAX)
        begin
            m = 7'd0;
            h = h + 6'd1;
        end
        if (h > HOUR_MAX)
        begin
            h = 6'd0;
            m = 7'd0;
            s = 7'd0;
        end
        return {h[4:0], m[5:0], s[5:0]};
    endfunction

endpackage

>>> rtl/ucc_req_if.sv
// ----------------------------------------------------------------------------
// ucc_req_if
// input channel: tick or log read transaction with valid/ready handshake
// ----------------------------------------------------------------------------
interface ucc_req_if;
    logic                               valid;
    logic                               ready;
    logic                               func;
    logic                               echo_a;
    logic                               echo_b;
    logic                               log_which;
    logic [ucc_pkg::LOG_INDEX_W-1:0]    log_index;

    modport source (output valid, output func, output echo_a, output echo_b,
                    output log_which, output log_index, input ready);
    modport sink   (input valid, input func, input echo_a, input echo_b,
                    input log_which, input log_index, output ready);
endinterface

>>> rtl/ucc_rsp_if.sv
// ----------------------------------------------------------------------------
// ucc_rsp_if
// result channel: pin levels, counters, time and log data with valid/ready
// ----------------------------------------------------------------------------
interface ucc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               trig_a;
    logic                               trig_b;
    logic [ucc_pkg::COUNT_OUT_W-1:0]    occupancy;
    logic [ucc_pkg::COUNT_OUT_W-1:0]    peak;
    logic [ucc_pkg::COUNT_OUT_W-1:0]    total;
    logic [ucc_pkg::TIME_W-1:0]         clock_time;
    logic                               entered;
    logic                               exited;
    logic [ucc_pkg::TIME_W-1:0]         log_time;

    modport source (output valid, output trig_a, output trig_b, output occupancy,
                    output peak, output total, output clock_time, output entered,
                    output exited, output log_time, input ready);
    modport sink   (input valid, input trig_a, input trig_b, input occupancy,
                    input peak, input total, input clock_time, input entered,
                    input exited, input log_time, output ready);
endinterface

>>> rtl/ultrasonic_occupancy_counter_core.sv
// ----------------------------------------------------------------------------
// ultrasonic_occupancy_counter_core
// two-sensor people counter: trigger/echo sequencing, time of day, event logs
//
//   channel  direction  handshake        contents
//   req      in         valid/ready      func, echo_a, echo_b, log_which, log_index
//   rsp      out        valid/ready      trigs, counters, clock_time, events, log_time
//   cfg      in         cfg_we only      cfg_index, cfg_data
//
// one transaction per cycle while rsp keeps up: the state update and result are
// computed in the accept cycle and the result register presents them on the next cycle.
// req.ready is high while the result register is empty or being drained, so a
// stalled rsp holds one result and blocks further input until taken.
// reset clears the sequencer, timers, counters, clock and both logs at once.
// ----------------------------------------------------------------------------
module ultrasonic_occupancy_counter_core #(
    parameter int LOG_DEPTH   = ucc_pkg::LOG_DEPTH_DEF,
    parameter int COUNT_WIDTH = ucc_pkg::COUNT_WIDTH_DEF,
    parameter int ECHO_WIDTH  = ucc_pkg::ECHO_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ucc_req_if.sink                           req,
    ucc_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [ucc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ucc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int FILL_W = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [ECHO_WIDTH-1:0]  ECHO_MAX  = {ECHO_WIDTH{1'b1}};

    // configuration
    logic [ucc_pkg::THRESH_W-1:0]    near_threshold_reg;
    logic [ucc_pkg::INTERVAL_W-1:0]  read_interval_reg;
    logic [ucc_pkg::LOCKOUT_W-1:0]   lockout_ticks_reg;
    logic [ucc_pkg::TPS_W-1:0]       ticks_per_second_reg;

    // state
    ucc_pkg::phase_t                 phase_reg, phase_next;
    logic [ucc_pkg::PHASE_CNT_W-1:0] phase_count_reg, phase_count_next;
    logic [ECHO_WIDTH-1:0]           width_a_reg, width_a_next;
    logic [ECHO_WIDTH-1:0]           width_b_reg, width_b_next;
    logic [ucc_pkg::TPS_W-1:0]       second_count_reg, second_count_next;
    logic [ucc_pkg::INTERVAL_W-1:0]  read_wait_reg, read_wait_next;
    logic [ucc_pkg::LOCKOUT_W-1:0]   clear_wait_reg, clear_wait_next;
    logic                            read_ready_reg, read_ready_next;
    logic                            sense_clear_reg, sense_clear_next;
    logic [COUNT_WIDTH-1:0]          occupancy_reg, occupancy_next;
    logic [COUNT_WIDTH-1:0]          peak_reg, peak_next;
    logic [COUNT_WIDTH-1:0]          total_reg, total_next;
    logic [ucc_pkg::TIME_W-1:0]      time_of_day_reg, time_of_day_next;
    logic [ucc_pkg::TIME_W-1:0]      entry_log_reg [LOG_DEPTH];
    logic [ucc_pkg::TIME_W-1:0]      entry_log_next [LOG_DEPTH];
    logic [ucc_pkg::TIME_W-1:0]      exit_log_reg [LOG_DEPTH];
    logic [ucc_pkg::TIME_W-1:0]      exit_log_next [LOG_DEPTH];
    logic [FILL_W-1:0]               entry_fill_reg, entry_fill_next;
    logic [FILL_W-1:0]               exit_fill_reg, exit_fill_next;

    // result register
    logic                            rsp_valid_reg;
    ucc_pkg::rsp_t                   rsp_reg, rsp_next;

    logic                            accept;
    logic                            entered;
    logic                            exited;
    logic [ucc_pkg::TIME_W-1:0]      log_time;
    logic [IDX_W-1:0]                rd_idx;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign rd_idx    = IDX_W'(req.log_index);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg   <= ucc_pkg::NEAR_THRESHOLD_RST;
            read_interval_reg    <= ucc_pkg::READ_INTERVAL_RST;
            lockout_ticks_reg    <= ucc_pkg::LOCKOUT_TICKS_RST;
            ticks_per_second_reg <= ucc_pkg::TICKS_PER_SECOND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ucc_pkg::CFG_NEAR_THRESHOLD:
                    near_threshold_reg <= cfg_data[ucc_pkg::THRESH_W-1:0];
                ucc_pkg::CFG_READ_INTERVAL:
                    read_interval_reg <= cfg_data[ucc_pkg::INTERVAL_W-1:0];
                ucc_pkg::CFG_LOCKOUT_TICKS:
                    lockout_ticks_reg <= cfg_data[ucc_pkg::LOCKOUT_W-1:0];
                ucc_pkg::CFG_TICKS_PER_SECOND:
                    ticks_per_second_reg <= cfg_data[ucc_pkg::TPS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // next state and result
    always_comb
    begin
        phase_next        = phase_reg;
        phase_count_next  = phase_count_reg;
        width_a_next      = width_a_reg;
        width_b_next      = width_b_reg;
        second_count_next = second_count_reg;
        read_wait_next    = read_wait_reg;
        clear_wait_next   = clear_wait_reg;
        read_ready_next   = read_ready_reg;
        sense_clear_next  = sense_clear_reg;
        occupancy_next    = occupancy_reg;
        peak_next         = peak_reg;
        total_next        = total_reg;
        time_of_day_next  = time_of_day_reg;
        entry_log_next    = entry_log_reg;
        exit_log_next     = exit_log_reg;
        entry_fill_next   = entry_fill_reg;
        exit_fill_next    = exit_fill_reg;
        entered           = 1'b0;
        exited            = 1'b0;
        log_time          = '0;

        if (accept)
        begin
            if (req.func == ucc_pkg::FUNC_TICK)
            begin
                // timers
                second_count_next = second_count_reg + 1'b1;
                if (second_count_next >= ticks_per_second_reg)
                begin
                    second_count_next = '0;
                    time_of_day_next  = ucc_pkg::clock_advance(time_of_day_reg);
                end
                read_wait_next = read_wait_reg + 1'b1;
                if (read_wait_next >= read_interval_reg)
                begin
                    read_wait_next  = '0;
                    read_ready_next = 1'b1;
                end
                clear_wait_next = clear_wait_reg + 1'b1;
                if (clear_wait_next >= lockout_ticks_reg)
                begin
                    clear_wait_next  = '0;
                    sense_clear_next = 1'b1;
                end

                // measurement sequencer
                case (phase_reg)
                    ucc_pkg::PH_A_LOW, ucc_pkg::PH_B_LOW:
                    begin
                        phase_count_next = phase_count_reg + 1'b1;
                        if (phase_count_next >= ucc_pkg::LOW_TICKS)
                        begin
                            phase_count_next = '0;
                            phase_next = (phase_reg == ucc_pkg::PH_A_LOW) ?
                                         ucc_pkg::PH_A_HIGH : ucc_pkg::PH_B_HIGH;
                        end
                    end
                    ucc_pkg::PH_A_HIGH, ucc_pkg::PH_B_HIGH:
                    begin
                        phase_count_next = phase_count_reg + 1'b1;
                        if (phase_count_next >= ucc_pkg::HIGH_TICKS)
                        begin
                            phase_count_next = '0;
                            phase_next = (phase_reg == ucc_pkg::PH_A_HIGH) ?
                                         ucc_pkg::PH_A_WAIT : ucc_pkg::PH_B_WAIT;
                        end
                    end
                    ucc_pkg::PH_A_WAIT:
                    begin
                        if (req.echo_a)
                        begin
                            width_a_next = ECHO_WIDTH'(1);
                            phase_next   = ucc_pkg::PH_A_COUNT;
                        end
                    end
                    ucc_pkg::PH_A_COUNT:
                    begin
                        if (req.echo_a)
                        begin
                            if (width_a_reg != ECHO_MAX)
                                width_a_next = width_a_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next       = ucc_pkg::PH_B_LOW;
                            phase_count_next = '0;
                        end
                    end
                    ucc_pkg::PH_B_WAIT:
                    begin
                        if (req.echo_b)
                        begin
                            width_b_next = ECHO_WIDTH'(1);
                            phase_next   = ucc_pkg::PH_B_COUNT;
                        end
                    end
                    ucc_pkg::PH_B_COUNT:
                    begin
                        if (req.echo_b)
                        begin
                            if (width_b_reg != ECHO_MAX)
                                width_b_next = width_b_reg + 1'b1;
                        end
                        else
                        begin
                            phase_next       = ucc_pkg::PH_IDLE;
                            phase_count_next = '0;
                            read_wait_next   = '0;
                            read_ready_next  = 1'b0;
                            if (32'(width_a_reg) < 32'(near_threshold_reg))
                            begin
                                // entry
                                if (int'(entry_fill_reg) < LOG_DEPTH)
                                begin
                                    for (int k = 0; k < LOG_DEPTH; k++)
                                    begin
                                        if (int'(entry_fill_reg) == k)
                                            entry_log_next[k] = time_of_day_next;
                                    end
                                    entry_fill_next = entry_fill_reg + 1'b1;
                                end
                                else
                                begin
                                    for (int k = 0; k < LOG_DEPTH - 1; k++)
                                        entry_log_next[k] = entry_log_reg[k+1];
                                    entry_log_next[LOG_DEPTH-1] = time_of_day_next;
                                end
                                if (occupancy_reg != COUNT_MAX)
                                    occupancy_next = occupancy_reg + 1'b1;
                                if (total_reg != COUNT_MAX)
                                    total_next = total_reg + 1'b1;
                                if (occupancy_next > peak_reg)
                                    peak_next = occupancy_next;
                                clear_wait_next  = '0;
                                sense_clear_next = 1'b0;
                                entered          = 1'b1;
                            end
                            else if (32'(width_b_reg) < 32'(near_threshold_reg))
                            begin
                                // exit
                                if (int'(exit_fill_reg) < LOG_DEPTH)
                                begin
                                    for (int k = 0; k < LOG_DEPTH; k++)
                                    begin
                                        if (int'(exit_fill_reg) == k)
                                            exit_log_next[k] = time_of_day_next;
                                    end
                                    exit_fill_next = exit_fill_reg + 1'b1;
                                end
                                else
                                begin
                                    for (int k = 0; k < LOG_DEPTH - 1; k++)
                                        exit_log_next[k] = exit_log_reg[k+1];
                                    exit_log_next[LOG_DEPTH-1] = time_of_day_next;
                                end
                                if (occupancy_reg != '0)
                                    occupancy_next = occupancy_reg - 1'b1;
                                clear_wait_next  = '0;
                                sense_clear_next = 1'b0;
                                exited           = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next       = ucc_pkg::PH_IDLE;
                        phase_count_next = '0;
                        if (read_ready_next && sense_clear_next)
                        begin
                            read_ready_next = 1'b0;
                            phase_next      = ucc_pkg::PH_A_LOW;
                        end
                    end
                endcase
            end
            else if (int'(req.log_index) < LOG_DEPTH)
            begin
                log_time = (req.log_which == ucc_pkg::LOG_EXIT) ?
                           exit_log_reg[rd_idx] : entry_log_reg[rd_idx];
            end
        end

        rsp_next.trig_a     = (phase_next == ucc_pkg::PH_A_HIGH);
        rsp_next.trig_b     = (phase_next == ucc_pkg::PH_B_HIGH);
        rsp_next.occupancy  = ucc_pkg::COUNT_OUT_W'(occupancy_next);
        rsp_next.peak       = ucc_pkg::COUNT_OUT_W'(peak_next);
        rsp_next.total      = ucc_pkg::COUNT_OUT_W'(total_next);
        rsp_next.clock_time = time_of_day_next;
        rsp_next.entered    = entered;
        rsp_next.exited     = exited;
        rsp_next.log_time   = log_time;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ucc_pkg::PH_IDLE;
            phase_count_reg  <= '0;
            width_a_reg      <= '0;
            width_b_reg      <= '0;
            second_count_reg <= '0;
            read_wait_reg    <= '0;
            clear_wait_reg   <= '0;
            read_ready_reg   <= 1'b1;
            sense_clear_reg  <= 1'b1;
            occupancy_reg    <= '0;
            peak_reg         <= '0;
            total_reg        <= '0;
            time_of_day_reg  <= '0;
            entry_fill_reg   <= '0;
            exit_fill_reg    <= '0;
            for (int k = 0; k < LOG_DEPTH; k++)
            begin
                entry_log_reg[k] <= '0;
                exit_log_reg[k]  <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            phase_count_reg  <= phase_count_next;
            width_a_reg      <= width_a_next;
            width_b_reg      <= width_b_next;
            second_count_reg <= second_count_next;
            read_wait_reg    <= read_wait_next;
            clear_wait_reg   <= clear_wait_next;
            read_ready_reg   <= read_ready_next;
            sense_clear_reg  <= sense_clear_next;
            occupancy_reg    <= occupancy_next;
            peak_reg         <= peak_next;
            total_reg        <= total_next;
            time_of_day_reg  <= time_of_day_next;
            entry_fill_reg   <= entry_fill_next;
            exit_fill_reg    <= exit_fill_next;
            entry_log_reg    <= entry_log_next;
            exit_log_reg     <= exit_log_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.trig_a     = rsp_reg.trig_a;
    assign rsp.trig_b     = rsp_reg.trig_b;
    assign rsp.occupancy  = rsp_reg.occupancy;
    assign rsp.peak       = rsp_reg.peak;
    assign rsp.total      = rsp_reg.total;
    assign rsp.clock_time = rsp_reg.clock_time;
    assign rsp.entered    = rsp_reg.entered;
    assign rsp.exited     = rsp_reg.exited;
    assign rsp.log_time   = rsp_reg.log_time;

endmodule

>>> dv/tb_ultrasonic_occupancy_counter_core.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_occupancy_counter_core
// self-checking testbench for the two-sensor occupancy counter core
//
// Ticks and log reads are driven on the request channel in bursts with
// random gaps, while the result channel stalls on its own random pattern.
// A cycle-true predictor of the sequencer, timers, counters, clock and logs
// computes the status word for every accepted transaction. Each returned
// status word is then compared field by field in order. The directed tests
// cover:
//   - the power-on state and register extremes
//   - threshold edges and an exit at zero occupancy
//   - log shifting and the minute rollover of the clock
//   - a long echo width
//   - a long result stall
// A random run of well-formed measurements and noise follows.
// ----------------------------------------------------------------------------
module tb_ultrasonic_occupancy_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ucc_pkg::*;

    localparam int LOG_SLOTS = LOG_DEPTH_DEF;
    localparam logic [COUNT_OUT_W-1:0] COUNT_TOP = '1;
    localparam logic [15:0] ECHO_TOP = '1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ucc_req_if req_ch ();
    ucc_rsp_if rsp_ch ();

    ultrasonic_occupancy_counter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor configuration
    logic [THRESH_W-1:0]   thr_cfg;
    logic [INTERVAL_W-1:0] interval_cfg;
    logic [LOCKOUT_W-1:0]  lockout_cfg;
    logic [TPS_W-1:0]      tps_cfg;

    // predictor state
    phase_t                ph;
    logic [PHASE_CNT_W-1:0] ph_cnt;
    logic [15:0]           wid_a;
    logic [15:0]           wid_b;
    logic [TPS_W-1:0]      sec_cnt;
    logic [INTERVAL_W-1:0] rd_wait;
    logic [LOCKOUT_W-1:0]  clr_wait;
    logic                  rd_ready;
    logic                  clr_ok;
    logic [COUNT_OUT_W-1:0] occ;
    logic [COUNT_OUT_W-1:0] pk;
    logic [COUNT_OUT_W-1:0] tot;
    logic [TIME_W-1:0]     tod;
    logic [TIME_W-1:0]     event_log [2][LOG_SLOTS];
    int                    log_fill [2];

    rsp_t status_q [$];
    rsp_t want;

    int n_errors;
    int n_sent;
    int n_reads;
    int n_entries;
    int n_exits;
    int burst_left;
    int hold_left;
    int read_pct;
    bit sender_gaps;
    bit rx_stalls;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100_000_000;
        $display("%0t timeout with %0d status words outstanding", $time, status_q.size());
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic void clear_state();
        thr_cfg = NEAR_THRESHOLD_RST;
        interval_cfg = READ_INTERVAL_RST;
        lockout_cfg = LOCKOUT_TICKS_RST;
        tps_cfg = TICKS_PER_SECOND_RST;
        ph = PH_IDLE;
        ph_cnt = '0;
        wid_a = '0;
        wid_b = '0;
        sec_cnt = '0;
        rd_wait = '0;
        clr_wait = '0;
        rd_ready = 1'b1;
        clr_ok = 1'b1;
        occ = '0;
        pk = '0;
        tot = '0;
        tod = '0;
        for (int w = 0; w < 2; w++)
        begin
            log_fill[w] = 0;
            for (int k = 0; k < LOG_SLOTS; k++)
                event_log[w][k] = '0;
        end
    endfunction

    function automatic logic [TIME_W-1:0] tick_second(input logic [TIME_W-1:0] t);
        int h;
        int m;
        int s;
        h = t[16:12];
        m = t[11:6];
        s = t[5:0];
        s++;
        if (s > SEC_MAX)
        begin
            s = 0;
            m++;
        end
        if (m > MIN_MAX)
        begin
            m = 0;
            h++;
        end
        if (h > HOUR_MAX)
        begin
            h = 0;
            m = 0;
            s = 0;
        end
        return {h[4:0], m[5:0], s[5:0]};
    endfunction

    function automatic void log_event(input logic which);
        if (log_fill[which] < LOG_SLOTS)
        begin
            event_log[which][log_fill[which]] = tod;
            log_fill[which]++;
        end
        else
        begin
            for (int k = 0; k < LOG_SLOTS - 1; k++)
                event_log[which][k] = event_log[which][k + 1];
            event_log[which][LOG_SLOTS - 1] = tod;
        end
    endfunction

    // status word after one transaction, advancing the predicted state
    function automatic rsp_t next_status(input logic f, input logic ea, input logic eb,
                                         input logic lw, input logic [LOG_INDEX_W-1:0] li);
        rsp_t r;
        r = '0;
        if (f == FUNC_TICK)
        begin
            sec_cnt = sec_cnt + 1'b1;
            if (sec_cnt >= tps_cfg)
            begin
                sec_cnt = '0;
                tod = tick_second(tod);
            end
            rd_wait = rd_wait + 1'b1;
            if (rd_wait >= interval_cfg)
            begin
                rd_wait = '0;
                rd_ready = 1'b1;
            end
            clr_wait = clr_wait + 1'b1;
            if (clr_wait >= lockout_cfg)
            begin
                clr_wait = '0;
                clr_ok = 1'b1;
            end
            case (ph)
                PH_A_LOW, PH_B_LOW:
                begin
                    ph_cnt = ph_cnt + 1'b1;
                    if (ph_cnt >= LOW_TICKS)
                    begin
                        ph_cnt = '0;
                        if (ph == PH_A_LOW)
                            ph = PH_A_HIGH;
                        else
                            ph = PH_B_HIGH;
                    end
                end
                PH_A_HIGH, PH_B_HIGH:
                begin
                    ph_cnt = ph_cnt + 1'b1;
                    if (ph_cnt >= HIGH_TICKS)
                    begin
                        ph_cnt = '0;
                        if (ph == PH_A_HIGH)
                            ph = PH_A_WAIT;
                        else
                            ph = PH_B_WAIT;
                    end
                end
                PH_A_WAIT:
                begin
                    if (ea)
                    begin
                        wid_a = 16'd1;
                        ph = PH_A_COUNT;
                    end
                end
                PH_A_COUNT:
                begin
                    if (ea)
                    begin
                        if (wid_a != ECHO_TOP)
                            wid_a = wid_a + 1'b1;
                    end
                    else
                    begin
                        ph = PH_B_LOW;
                        ph_cnt = '0;
                    end
                end
                PH_B_WAIT:
                begin
                    if (eb)
                    begin
                        wid_b = 16'd1;
                        ph = PH_B_COUNT;
                    end
                end
                PH_B_COUNT:
                begin
                    if (eb)
                    begin
                        if (wid_b != ECHO_TOP)
                            wid_b = wid_b + 1'b1;
                    end
                    else
                    begin
                        ph = PH_IDLE;
                        ph_cnt = '0;
                        rd_wait = '0;
                        rd_ready = 1'b0;
                        if (wid_a < thr_cfg)
                        begin
                            log_event(LOG_ENTRY);
                            if (occ != COUNT_TOP)
                                occ = occ + 1'b1;
                            if (tot != COUNT_TOP)
                                tot = tot + 1'b1;
                            if (occ > pk)
                                pk = occ;
                            clr_wait = '0;
                            clr_ok = 1'b0;
                            r.entered = 1'b1;
                            n_entries++;
                        end
                        else if (wid_b < thr_cfg)
                        begin
                            log_event(LOG_EXIT);
                            if (occ != '0)
                                occ = occ - 1'b1;
                            clr_wait = '0;
                            clr_ok = 1'b0;
                            r.exited = 1'b1;
                            n_exits++;
                        end
                    end
                end
                default:
                begin
                    ph = PH_IDLE;
                    ph_cnt = '0;
                    if (rd_ready && clr_ok)
                    begin
                        rd_ready = 1'b0;
                        ph = PH_A_LOW;
                    end
                end
            endcase
        end
        else if (li < LOG_SLOTS)
            r.log_time = event_log[lw][li];
        r.trig_a = (ph == PH_A_HIGH);
        r.trig_b = (ph == PH_B_HIGH);
        r.occupancy = occ;
        r.peak = pk;
        r.total = tot;
        r.clock_time = tod;
        return r;
    endfunction

    task automatic send_item(input logic f, input logic ea, input logic eb, input logic lw,
                             input logic [LOG_INDEX_W-1:0] li);
        int gap;
        gap = 0;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = $urandom_range(1, 6);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.echo_a <= ea;
        req_ch.echo_b <= eb;
        req_ch.log_which <= lw;
        req_ch.log_index <= li;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        status_q.push_back(next_status(f, ea, eb, lw, li));
        n_sent++;
        if (f == FUNC_READ)
            n_reads++;
    endtask

    task automatic send_tick(input logic ea, input logic eb);
        if ($urandom_range(0, 99) < read_pct)
            send_item(FUNC_READ, coin(), coin(), coin(), LOG_INDEX_W'($urandom_range(0, 7)));
        send_item(FUNC_TICK, ea, eb, coin(), LOG_INDEX_W'($urandom_range(0, 7)));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_NEAR_THRESHOLD: thr_cfg = data[THRESH_W-1:0];
            CFG_READ_INTERVAL: interval_cfg = data[INTERVAL_W-1:0];
            CFG_LOCKOUT_TICKS: lockout_cfg = data[LOCKOUT_W-1:0];
            CFG_TICKS_PER_SECOND: tps_cfg = data[TPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int thr, input int interval, input int lockout,
                              input int tps);
        wait_idle();
        write_reg(CFG_NEAR_THRESHOLD, thr);
        write_reg(CFG_READ_INTERVAL, interval);
        write_reg(CFG_LOCKOUT_TICKS, lockout);
        write_reg(CFG_TICKS_PER_SECOND, tps);
    endtask

    // one full A then B measurement with the given echo delays and widths
    task automatic run_measurement(input int a_len, input int b_len, input int a_hold,
                                   input int b_hold);
        while (ph != PH_A_WAIT)
            send_tick(coin(), coin());
        repeat (a_hold) send_tick(1'b0, coin());
        repeat (a_len) send_tick(1'b1, coin());
        send_tick(1'b0, coin());
        while (ph != PH_B_WAIT)
            send_tick(coin(), coin());
        repeat (b_hold) send_tick(coin(), 1'b0);
        repeat (b_len) send_tick(coin(), 1'b1);
        send_tick(coin(), 1'b0);
    endtask

    function automatic int pick_width();
        int t;
        t = thr_cfg;
        case ($urandom_range(0, 3))
            0: return (t > 1) ? t - 1 : 1;
            1: return (t > 0) ? t : 1;
            2: return t + 1;
            default: return $urandom_range(1, 2 * t + 4);
        endcase
    endfunction

    task automatic read_all_slots();
        for (int w = 0; w < 2; w++)
            for (int k = 0; k < 8; k++)
                send_item(FUNC_READ, coin(), coin(), 1'(w), LOG_INDEX_W'(k));
    endtask

    task automatic test_power_on();
        send_item(FUNC_READ, 1'b0, 1'b0, LOG_ENTRY, 3'd0);
        send_item(FUNC_READ, 1'b1, 1'b1, LOG_EXIT, 3'd4);
        send_item(FUNC_READ, 1'b0, 1'b1, LOG_ENTRY, 3'd7);
        repeat (16) send_tick(1'b0, coin());
    endtask

    task automatic test_register_extremes();
        set_config(65535, 262143, 2097151, 1048575);
        run_measurement(3, 3, 0, 0);
        set_config(0, 0, 0, 0);
        run_measurement(1, 1, 0, 0);
    endtask

    task automatic test_threshold_edges();
        set_config(6, 3, 5, 7);
        run_measurement(6, 5, 0, 0);
        run_measurement(5, 9, 1, 0);
        run_measurement(6, 6, 0, 2);
        run_measurement(7, 5, 0, 0);
        run_measurement(7, 5, 0, 0);
        run_measurement(2, 3, 10, 10);
    endtask

    task automatic test_log_shift();
        set_config(4, 1, 2, 0);
        repeat (6) run_measurement(1, 1, 0, 0);
        repeat (6) run_measurement(8, 2, 0, 1);
        read_all_slots();
    endtask

    task automatic test_clock_rollover();
        sender_gaps = 1'b0;
        rx_stalls = 1'b0;
        read_pct = 0;
        set_config(0, 1, 1, 1);
        repeat (65) send_tick(coin(), coin());
        read_all_slots();
    endtask

    task automatic test_long_echo();
        set_config(65535, 1, 1, 1048575);
        run_measurement(60, 2, 0, 0);
        read_all_slots();
        sender_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    task automatic test_result_stall();
        set_config(3, 2, 4, 5);
        read_pct = 15;
        hold_left = 200;
        repeat (40) send_tick(coin(), coin());
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at)
        begin
            set_config($urandom_range(0, 20), $urandom_range(0, 30), $urandom_range(0, 80),
                       $urandom_range(0, 40));
            sender_gaps = ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            read_pct = $urandom_range(0, 20);
            repeat ($urandom_range(3, 8))
            begin
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 25)) send_tick(coin(), coin());
                    1: run_measurement(pick_width(), pick_width(), $urandom_range(10, 40),
                                       $urandom_range(10, 40));
                    default: run_measurement(pick_width(), pick_width(),
                                             $urandom_range(0, 3), $urandom_range(0, 3));
                endcase
            end
        end
    endtask

    // result channel stall pattern and long hold-off
    initial
    begin
        int run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!rx_stalls)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    level = ($urandom_range(0, 9) < 7);
                    run_left = $urandom_range(1, 8);
                end
                run_left--;
                rsp_ch.ready <= level;
            end
        end
    end

    task automatic check_field(input string name, input logic [TIME_W-1:0] exp_val,
                               input logic [TIME_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t mismatch on %s: expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $display("%0t unexpected transaction: expected none, actual occupancy %0d",
                         $time, rsp_ch.occupancy);
                n_errors++;
            end
            else
            begin
                want = status_q.pop_front();
                check_field("trig_a", want.trig_a, rsp_ch.trig_a);
                check_field("trig_b", want.trig_b, rsp_ch.trig_b);
                check_field("occupancy", want.occupancy, rsp_ch.occupancy);
                check_field("peak", want.peak, rsp_ch.peak);
                check_field("total", want.total, rsp_ch.total);
                check_field("clock_time", want.clock_time, rsp_ch.clock_time);
                check_field("entered", want.entered, rsp_ch.entered);
                check_field("exited", want.exited, rsp_ch.exited);
                check_field("log_time", want.log_time, rsp_ch.log_time);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_TICK;
        req_ch.echo_a = 1'b0;
        req_ch.echo_b = 1'b0;
        req_ch.log_which = LOG_ENTRY;
        req_ch.log_index = '0;
        n_errors = 0;
        n_sent = 0;
        n_reads = 0;
        n_entries = 0;
        n_exits = 0;
        burst_left = 0;
        hold_left = 0;
        read_pct = 0;
        sender_gaps = 1'b1;
        rx_stalls = 1'b1;
        clear_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on();
        test_register_extremes();
        test_threshold_edges();
        test_log_shift();
        test_clock_rollover();
        test_long_echo();
        test_result_stall();
        test_random_traffic(200);

        wait_idle();
        repeat (10) @(posedge clk);
        $display("run covered %0d transactions with %0d log reads, %0d entries, %0d exits",
                 n_sent, n_reads, n_entries, n_exits);
        $display("plus register extremes, a minute rollover of the clock and a long echo");
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
